### hdl/priority_load_shedder_assert.svh
// Assertion macros for the priority load shedder.
`ifndef PRIORITY_LOAD_SHEDDER_ASSERT_SVH
`define PRIORITY_LOAD_SHEDDER_ASSERT_SVH

// same-cycle implication
`define PLS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PLS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/pls_pkg.sv
// Shared types and constants of the priority load shedder.
package pls_pkg;

   localparam int POWER_W  = 16;
   localparam int PRIO_W   = 8;
   localparam int TOTAL_W  = POWER_W + 1;
   localparam int STATUS_W = 2;
   localparam int LIDX_W   = 5;
   localparam int MASK_W   = 32;
   localparam int COUNT_W  = 6;

   localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd3;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_TOGGLE = 1'b1;

   typedef struct packed {
      logic [TOTAL_W-1:0] acc;
      logic [POWER_W-1:0] operand;
      logic               sub;
   } alu_req_type;

   typedef struct packed {
      logic [TOTAL_W-1:0] result;
      logic               over;
   } alu_rsp_type;

endpackage

### hdl/pls_alu.sv
// Shared power accumulator: add or subtract one load and compare against the limit.
module pls_alu (
   input  pls_pkg::alu_req_type          alu_req,
   input  logic [pls_pkg::POWER_W-1:0]   limit,
   output pls_pkg::alu_rsp_type          alu_rsp
);

   logic [pls_pkg::TOTAL_W-1:0] operand_ext;
   logic [pls_pkg::TOTAL_W-1:0] limit_ext;
   logic [pls_pkg::TOTAL_W-1:0] result;

   assign operand_ext = {1'b0, alu_req.operand};
   assign limit_ext   = {1'b0, limit};
   assign result      = alu_req.sub ? (alu_req.acc - operand_ext)
                                    : (alu_req.acc + operand_ext);

   assign alu_rsp.result = result;
   assign alu_rsp.over   = (result > limit_ext);

endmodule

### hdl/priority_load_shedder.sv
// Priority load shedder top level: load table, sequencer and result register.
//
// Keeps up to MAX_LOADS loads sorted by priority (high first), then power (low
// first), in a table memory with one write port and one registered read port.
// Each request transaction is processed alone; ready is high only while the
// sequencer is idle, and one response transaction follows each request. All
// power sums and limit compares go through one shared adder, one table entry
// per step, so the memory read latency sets the pace. A full-table insert or
// an out of range toggle goes straight to the response. An insert examines
// entries from the last one towards the top of the table, moving each entry
// that ranks behind the new load down by one, and writes the new load into the
// gap. A toggle is refused when the load alone exceeds the limit; otherwise the
// load is flipped, and if the total then exceeds the limit, a shed pass turns
// off other loads from the last entry upwards until the total fits, and a
// restore pass from the top retries each shed load and turns it back on where
// it fits. Once the response register is loaded the sequencer is idle again;
// the result sits there, so the next request is taken while a response waits.
`include "priority_load_shedder_assert.svh"

module priority_load_shedder #(
   parameter int MAX_LOADS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_opcode,
   input  logic [pls_pkg::LIDX_W-1:0]      req_load_index,
   input  logic [pls_pkg::POWER_W-1:0]     req_load_power,
   input  logic [pls_pkg::PRIO_W-1:0]      req_load_priority,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [pls_pkg::STATUS_W-1:0]    rsp_status,
   output logic [pls_pkg::POWER_W-1:0]     rsp_used_power,
   output logic [pls_pkg::MASK_W-1:0]      rsp_on_mask,
   output logic [pls_pkg::COUNT_W-1:0]     rsp_load_count,
   input  logic                            csr_wr_en,
   input  logic [pls_pkg::POWER_W-1:0]     csr_wr_data
);

   localparam int CW   = $clog2(MAX_LOADS + 1);
   localparam int AW   = (MAX_LOADS > 1) ? $clog2(MAX_LOADS) : 1;
   localparam int CMPW = (CW > pls_pkg::LIDX_W) ? CW : pls_pkg::LIDX_W;
   localparam int EW   = pls_pkg::PRIO_W + pls_pkg::POWER_W;
   localparam int PW   = pls_pkg::POWER_W;
   localparam int TW   = pls_pkg::TOTAL_W;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_INS_RD    = 4'd1;
   localparam logic [3:0] S_INS_EX    = 4'd2;
   localparam logic [3:0] S_INS_PUT   = 4'd3;
   localparam logic [3:0] S_TOG_RD    = 4'd4;
   localparam logic [3:0] S_TOG_CHK   = 4'd5;
   localparam logic [3:0] S_TOG_FLIP  = 4'd6;
   localparam logic [3:0] S_SHED_NEXT = 4'd7;
   localparam logic [3:0] S_SHED_RD   = 4'd8;
   localparam logic [3:0] S_SHED_EX   = 4'd9;
   localparam logic [3:0] S_REST_NEXT = 4'd10;
   localparam logic [3:0] S_REST_RD   = 4'd11;
   localparam logic [3:0] S_REST_EX   = 4'd12;
   localparam logic [3:0] S_DONE      = 4'd13;

   logic [3:0]                     state_ff, state_in;
   logic [PW-1:0]                  max_power_ff, max_power_in;
   logic [CW-1:0]                  count_ff, count_in;
   logic [TW-1:0]                  total_ff, total_in;
   logic [MAX_LOADS-1:0]           on_ff, on_in;
   logic [MAX_LOADS-1:0]           shed_ff, shed_in;
   logic [CW-1:0]                  ptr_ff, ptr_in;
   logic [AW-1:0]                  addr_ff, addr_in;
   logic [AW-1:0]                  idx_ff, idx_in;
   logic                           op_ff, op_in;
   logic [PW-1:0]                  new_power_ff, new_power_in;
   logic [pls_pkg::PRIO_W-1:0]     new_prio_ff, new_prio_in;
   logic [pls_pkg::STATUS_W-1:0]   status_ff, status_in;
   logic [EW-1:0]                  rd_data_ff;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [pls_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [PW-1:0]                  rsp_power_ff, rsp_power_in;
   logic [pls_pkg::MASK_W-1:0]     rsp_mask_ff, rsp_mask_in;
   logic [pls_pkg::COUNT_W-1:0]    rsp_count_ff, rsp_count_in;

   logic [EW-1:0]                  table_mem [MAX_LOADS];
   logic                           mem_we;
   logic [AW-1:0]                  mem_waddr;
   logic [EW-1:0]                  mem_wdata;

   pls_pkg::alu_req_type           alu_req;
   pls_pkg::alu_rsp_type           alu_rsp;

   logic [CW-1:0]                  ptr_m1;
   logic [CW-1:0]                  ptr_m2;
   logic [CMPW-1:0]                idx_wide;
   logic                           idx_ok;
   logic [PW-1:0]                  rd_power;
   logic [pls_pkg::PRIO_W-1:0]     rd_prio;
   logic                           rank_ahead;
   logic                           load_rsp;
   logic [pls_pkg::MASK_W-1:0]     mask_now;
   logic [TW-1:0]                  limit_ext;

   assign ptr_m1     = ptr_ff - CW'(1);
   assign ptr_m2     = ptr_ff - CW'(2);
   assign idx_wide   = CMPW'(req_load_index);
   assign idx_ok     = (idx_wide < CMPW'(count_ff));
   assign rd_power   = rd_data_ff[PW-1:0];
   assign rd_prio    = rd_data_ff[EW-1:PW];
   assign rank_ahead = (rd_prio > new_prio_ff) ||
                       ((rd_prio == new_prio_ff) && (rd_power <= new_power_ff));
   assign limit_ext  = {1'b0, max_power_ff};

   genvar b;
   generate
      for (b = 0; b < pls_pkg::MASK_W; b++) begin : g_mask
         if (b < MAX_LOADS) begin : g_on
            assign mask_now[b] = on_ff[b];
         end else begin : g_off
            assign mask_now[b] = 1'b0;
         end
      end
   endgenerate

   pls_alu u_alu (
      .alu_req (alu_req),
      .limit   (max_power_ff),
      .alu_rsp (alu_rsp)
   );

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_used_power = rsp_power_ff;
   assign rsp_on_mask    = rsp_mask_ff;
   assign rsp_load_count = rsp_count_ff;

   assign load_rsp = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      max_power_in = csr_wr_en ? csr_wr_data : max_power_ff;
      state_in     = state_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      on_in        = on_ff;
      shed_in      = shed_ff;
      ptr_in       = ptr_ff;
      addr_in      = addr_ff;
      idx_in       = idx_ff;
      op_in        = op_ff;
      new_power_in = new_power_ff;
      new_prio_in  = new_prio_ff;
      status_in    = status_ff;
      mem_we       = 1'b0;
      mem_waddr    = ptr_ff[AW-1:0];
      mem_wdata    = rd_data_ff;
      alu_req.acc     = total_ff;
      alu_req.operand = '0;
      alu_req.sub     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in        = req_opcode;
               new_power_in = req_load_power;
               new_prio_in  = req_load_priority;
               if (req_opcode == pls_pkg::OP_INSERT) begin
                  if (count_ff == CW'(MAX_LOADS)) begin
                     status_in = pls_pkg::ST_FULL;
                     state_in  = S_DONE;
                  end else begin
                     ptr_in = count_ff;
                     if (count_ff == '0) begin
                        state_in = S_INS_PUT;
                     end else begin
                        addr_in  = count_ff[AW-1:0] - AW'(1);
                        state_in = S_INS_RD;
                     end
                  end
               end else begin
                  if (idx_ok) begin
                     idx_in   = idx_wide[AW-1:0];
                     addr_in  = idx_wide[AW-1:0];
                     state_in = S_TOG_RD;
                  end else begin
                     status_in = pls_pkg::ST_RANGE;
                     state_in  = S_DONE;
                  end
               end
            end
         end
         S_INS_RD: begin
            state_in = S_INS_EX;
         end
         S_INS_EX: begin
            if (rank_ahead) begin
               state_in = S_INS_PUT;
            end else begin
               mem_we = 1'b1;
               on_in[ptr_ff[AW-1:0]] = on_ff[ptr_m1[AW-1:0]];
               ptr_in = ptr_m1;
               if (ptr_m1 == '0) begin
                  state_in = S_INS_PUT;
               end else begin
                  addr_in  = ptr_m2[AW-1:0];
                  state_in = S_INS_RD;
               end
            end
         end
         S_INS_PUT: begin
            mem_we    = 1'b1;
            mem_wdata = {new_prio_ff, new_power_ff};
            on_in[ptr_ff[AW-1:0]] = 1'b0;
            count_in  = count_ff + CW'(1);
            status_in = pls_pkg::ST_DONE;
            state_in  = S_DONE;
         end
         S_TOG_RD: begin
            state_in = S_TOG_CHK;
         end
         S_TOG_CHK: begin
            alu_req.acc     = '0;
            alu_req.operand = rd_power;
            if (alu_rsp.over) begin
               status_in = pls_pkg::ST_REFUSED;
               state_in  = S_DONE;
            end else begin
               state_in = S_TOG_FLIP;
            end
         end
         S_TOG_FLIP: begin
            alu_req.operand = rd_power;
            alu_req.sub     = on_ff[idx_ff];
            total_in        = alu_rsp.result;
            on_in[idx_ff]   = ~on_ff[idx_ff];
            if (alu_rsp.over) begin
               shed_in  = '0;
               ptr_in   = count_ff;
               state_in = S_SHED_NEXT;
            end else begin
               status_in = pls_pkg::ST_DONE;
               state_in  = S_DONE;
            end
         end
         S_SHED_NEXT: begin
            if ((ptr_ff == '0) || !alu_rsp.over) begin
               ptr_in   = '0;
               state_in = S_REST_NEXT;
            end else begin
               ptr_in = ptr_m1;
               if (on_ff[ptr_m1[AW-1:0]] && (ptr_m1[AW-1:0] != idx_ff)) begin
                  addr_in  = ptr_m1[AW-1:0];
                  state_in = S_SHED_RD;
               end
            end
         end
         S_SHED_RD: begin
            state_in = S_SHED_EX;
         end
         S_SHED_EX: begin
            alu_req.operand = rd_power;
            alu_req.sub     = 1'b1;
            total_in        = alu_rsp.result;
            on_in[ptr_ff[AW-1:0]]   = 1'b0;
            shed_in[ptr_ff[AW-1:0]] = 1'b1;
            state_in        = S_SHED_NEXT;
         end
         S_REST_NEXT: begin
            if (ptr_ff == count_ff) begin
               status_in = pls_pkg::ST_DONE;
               state_in  = S_DONE;
            end else if (shed_ff[ptr_ff[AW-1:0]]) begin
               addr_in  = ptr_ff[AW-1:0];
               state_in = S_REST_RD;
            end else begin
               ptr_in = ptr_ff + CW'(1);
            end
         end
         S_REST_RD: begin
            state_in = S_REST_EX;
         end
         S_REST_EX: begin
            alu_req.operand = rd_power;
            if (!alu_rsp.over) begin
               total_in = alu_rsp.result;
               on_in[ptr_ff[AW-1:0]] = 1'b1;
            end
            ptr_in   = ptr_ff + CW'(1);
            state_in = S_REST_NEXT;
         end
         S_DONE: begin
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_power_in  = rsp_power_ff;
      rsp_mask_in   = rsp_mask_ff;
      rsp_count_in  = rsp_count_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_power_in  = total_ff[TW-1] ? {PW{1'b1}} : total_ff[PW-1:0];
         rsp_mask_in   = mask_now;
         rsp_count_in  = pls_pkg::COUNT_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         max_power_ff <= '0;
         count_ff     <= '0;
         total_ff     <= '0;
         on_ff        <= '0;
         shed_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         max_power_ff <= max_power_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         on_ff        <= on_in;
         shed_ff      <= shed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      addr_ff       <= addr_in;
      idx_ff        <= idx_in;
      op_ff         <= op_in;
      new_power_ff  <= new_power_in;
      new_prio_ff   <= new_prio_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_power_ff  <= rsp_power_in;
      rsp_mask_ff   <= rsp_mask_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // load table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= table_mem[addr_ff];
   end

   `PLS_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(MAX_LOADS), "load count above capacity")
   `PLS_ASSERT_IMP(a_on_in_table, clock, reset, state_ff == S_IDLE, (on_ff >> count_ff) == '0, "load on outside the table")
   `PLS_ASSERT_IMP(a_no_underflow, clock, reset, alu_req.sub, alu_req.acc >= alu_req.operand, "power total underflow")
   `PLS_ASSERT_IMP(a_fit_after_toggle, clock, reset, (state_ff == S_DONE) && (op_ff == pls_pkg::OP_TOGGLE) && (status_ff == pls_pkg::ST_DONE), total_ff <= limit_ext, "total above limit after toggle")
   `PLS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "ready held after request transaction")

endmodule
